// ===== rtl/bcsm_pkg.sv =====
// Shared widths, codes, payload types and MAC control type of the battery charge status monitor.
package bcsm_pkg;

  // Sample pairs per ADC block, kept a power of two so the block divide is a shift.
  localparam int PAIRS_LOG2      = 7;
  localparam int PAIRS_PER_BLOCK = 1 << PAIRS_LOG2;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = PAIRS_LOG2 + SAMPLE_W;
  localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(PAIRS_PER_BLOCK * 65535);

  // Filtered sums carry 16 fraction bits and one bit of headroom.
  localparam int SMOOTH_W = SUM_W + 17;
  localparam int SPLIT_W  = (SMOOTH_W + 1) / 2;

  // Q16 fractions that may reach 1.0.
  localparam int Q_W = 17;
  localparam logic [Q_W-1:0] Q16_ONE = Q_W'(65536);
  localparam int ROUND_Q16 = 32768;

  // Shared multiply-accumulate unit.
  localparam int MAC_A_W = SUM_W;
  localparam int MAC_B_W = 17;
  localparam int PROD_W  = MAC_A_W + MAC_B_W;
  localparam int ACC_W   = SMOOTH_W + 17;

  // Millivolt conversion divides by PAIRS_PER_BLOCK * 2^32.
  localparam int MV_SHIFT     = PAIRS_LOG2 + 32;
  localparam int MV_W         = ACC_W - MV_SHIFT;
  localparam int HALF_DIV_EXP = MV_SHIFT - 1 - SPLIT_W;
  localparam int HALF_DIV     = 1 << HALF_DIV_EXP;

  // Configuration port.
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  // Charge level arithmetic.
  localparam logic [15:0] CHG_BASE_MV = 16'd3800;
  localparam logic [9:0]  LEVEL_FULL  = 10'd1000;
  localparam logic [9:0]  LEVEL_OVER  = 10'd980;
  localparam logic [7:0]  COUNT_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_TICK      = 2'd1,
    KIND_VBUS_DROP = 2'd2,
    KIND_NONE      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_UNDEF    = 3'd0,
    ST_WORKING  = 3'd1,
    ST_LOW      = 3'd2,
    ST_CHARGING = 3'd3,
    ST_CHARGED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_Q16   = 2'd1,
    SH_SPLIT = 2'd2
  } mac_shift_e;

  typedef struct packed {
    logic       issue;
    logic       clear;
    mac_shift_e shift;
  } mac_ctrl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] vbat_sample;
    logic [15:0] chrg_sample;
    logic        block_end;
    logic        usb_vbus_pin;
    logic        charging_pin;
    logic        standby_pin;
  } bcsm_in_t;

  typedef struct packed {
    logic [2:0]  status_code;
    logic        charge_enable;
    logic [9:0]  charge_level_permille;
    logic        level_updated;
    logic [15:0] battery_mv;
  } bcsm_out_t;

endpackage

// ===== rtl/bcsm_mac.sv =====
// Shared multiply-accumulate unit: registered product, then shifted accumulate.
module bcsm_mac import bcsm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctrl_t          ctrl_i,
  input  logic [MAC_A_W-1:0] op_a_i,
  input  logic [MAC_B_W-1:0] op_b_i,
  output logic [ACC_W-1:0]   acc_o
);

  logic [PROD_W-1:0] prod_q;
  mac_ctrl_t         ctrl_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  prod_ext;
  logic [ACC_W-1:0]  addend;

  // Align the registered product to the weight given with it.
  always_comb begin
    prod_ext = ACC_W'(prod_q);
    unique case (ctrl_q.shift)
      SH_NONE:  addend = prod_ext;
      SH_Q16:   addend = prod_ext << 16;
      SH_SPLIT: addend = prod_ext << SPLIT_W;
      default:  addend = prod_ext;
    endcase
  end

  // A clear beat starts a fresh sum with its own product.
  always_comb begin
    acc_d = acc_q;
    if (ctrl_q.issue) begin
      acc_d = (ctrl_q.clear ? '0 : acc_q) + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{issue: 1'b0, clear: 1'b0, shift: SH_NONE};
      acc_q  <= '0;
    end else begin
      ctrl_q <= ctrl_i;
      acc_q  <= acc_d;
    end
  end

  // Product register holds payload only.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/battery_charge_status_monitor_top.sv =====
// Battery charge status monitor: item handshake, state, control tick and filter sequencer.
// A sample pair without the block end mark, a control tick, a VBUS drop or an empty item
// is written to the output register when it is accepted, or waits as pending while that
// register is full. A block end pair runs the two sum filters with their millivolt
// conversions, then the three pin filters, on the shared multiply-accumulate unit; other
// items flow at one per cycle while no block is in progress and the output does not stall.
// Reset clears all filter, counter and status state and loads the register defaults.
module battery_charge_status_monitor_top import bcsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bcsm_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bcsm_out_t            out_data_o
);

  typedef enum logic [2:0] {
    CFG_VOLTAGE_ALPHA   = 3'd0,
    CFG_PRESENCE_ALPHA  = 3'd1,
    CFG_FULL_SCALE_MV   = 3'd2,
    CFG_PRESENCE_THRESH = 3'd3,
    CFG_USB_BAT_LIMIT   = 3'd4,
    CFG_LOW_BATTERY_MV  = 3'd5,
    CFG_USB_SETTLE      = 3'd6,
    CFG_LOW_SETTLE      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILT,
    S_PRES
  } seq_e;

  // Steps of one sum filter plus conversion, and of one pin filter.
  localparam logic [3:0] F_ROUND     = 4'd0;
  localparam logic [3:0] F_MUL_LO    = 4'd1;
  localparam logic [3:0] F_MUL_HI    = 4'd2;
  localparam logic [3:0] F_MUL_SUM   = 4'd3;
  localparam logic [3:0] F_DRAIN     = 4'd4;
  localparam logic [3:0] F_WR_SMOOTH = 4'd5;
  localparam logic [3:0] F_MV_LO     = 4'd6;
  localparam logic [3:0] F_MV_HI     = 4'd7;
  localparam logic [3:0] F_MV_DRAIN  = 4'd8;
  localparam logic [3:0] F_WR_MV     = 4'd9;
  localparam logic [3:0] P_ROUND     = 4'd0;
  localparam logic [3:0] P_MUL       = 4'd1;
  localparam logic [3:0] P_PIN       = 4'd2;
  localparam logic [3:0] P_DRAIN     = 4'd3;
  localparam logic [3:0] P_WR        = 4'd4;

  localparam logic [1:0] CH_VBAT  = 2'd0;
  localparam logic [1:0] CH_CHRG  = 2'd1;
  localparam logic [1:0] PIN_USB  = 2'd0;
  localparam logic [1:0] PIN_CHG  = 2'd1;
  localparam logic [1:0] PIN_DONE = 2'd2;

  // Configuration registers.
  logic [15:0]    v_alpha_q, p_alpha_q, full_scale_q, usb_limit_q, low_mv_q;
  logic [Q_W-1:0] thresh_q;
  logic [7:0]     usb_settle_q, low_settle_q;

  // Monitor state.
  logic [SUM_W-1:0]    vbat_sum_q, vbat_sum_d, chrg_sum_q, chrg_sum_d;
  logic [SMOOTH_W-1:0] vbat_s_q, vbat_s_d, chrg_s_q, chrg_s_d;
  logic [15:0]         bat_mv_q, bat_mv_d, chg_mv_q, chg_mv_d;
  logic [Q_W-1:0]      usb_pres_q, usb_pres_d, chg_pres_q, chg_pres_d;
  logic [Q_W-1:0]      done_pres_q, done_pres_d;
  logic [7:0]          usb_cnt_q, usb_cnt_d, low_cnt_q, low_cnt_d;
  status_e             status_q, status_d;
  logic                enable_q, enable_d;
  logic [9:0]          level_q, level_d;
  logic [2:0]          pins_q, pins_d;

  // Sequencer and output side.
  seq_e       state_q;
  logic [3:0] sub_q;
  logic [1:0] idx_q;
  logic       pend_q, pend_upd_q;
  logic       out_valid_q;
  bcsm_out_t  out_q;

  logic accept, slot_free, block_item, direct_done, direct_upd, seq_done;

  assign in_stall_o  = (state_q != S_IDLE) || pend_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign block_item  = (in_data_i.kind == KIND_SAMPLE) && in_data_i.block_end;
  assign direct_done = accept && !block_item;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_alpha_q    <= 16'd328;
      p_alpha_q    <= 16'd131;
      full_scale_q <= 16'd6840;
      thresh_q     <= 17'd45875;
      usb_limit_q  <= 16'd2000;
      low_mv_q     <= 16'd3500;
      usb_settle_q <= 8'd5;
      low_settle_q <= 8'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_VOLTAGE_ALPHA:   v_alpha_q    <= cfg_wdata_i[15:0];
        CFG_PRESENCE_ALPHA:  p_alpha_q    <= cfg_wdata_i[15:0];
        CFG_FULL_SCALE_MV:   full_scale_q <= cfg_wdata_i[15:0];
        CFG_PRESENCE_THRESH: thresh_q     <= cfg_wdata_i;
        CFG_USB_BAT_LIMIT:   usb_limit_q  <= cfg_wdata_i[15:0];
        CFG_LOW_BATTERY_MV:  low_mv_q     <= cfg_wdata_i[15:0];
        CFG_USB_SETTLE:      usb_settle_q <= cfg_wdata_i[7:0];
        CFG_LOW_SETTLE:      low_settle_q <= cfg_wdata_i[7:0];
      endcase
    end
  end

  // Saturating block sums.
  logic [SUM_W:0]   vbat_add, chrg_add;
  logic [SUM_W-1:0] vbat_sat, chrg_sat;

  assign vbat_add = {1'b0, vbat_sum_q} + (SUM_W+1)'(in_data_i.vbat_sample);
  assign chrg_add = {1'b0, chrg_sum_q} + (SUM_W+1)'(in_data_i.chrg_sample);
  assign vbat_sat = (vbat_add > (SUM_W+1)'(SUM_CAP)) ? SUM_CAP : vbat_add[SUM_W-1:0];
  assign chrg_sat = (chrg_add > (SUM_W+1)'(SUM_CAP)) ? SUM_CAP : chrg_add[SUM_W-1:0];

  // Charge level from the charger voltage: 2.5 per mille per millivolt above base.
  logic [15:0] lvl_x;
  logic [17:0] lvl_x5;
  logic [16:0] lvl_raw;
  logic [9:0]  lvl_val;

  always_comb begin
    lvl_x   = (chg_mv_q >= CHG_BASE_MV) ? (chg_mv_q - CHG_BASE_MV) : 16'd0;
    lvl_x5  = {lvl_x, 2'b00} + 18'(lvl_x);
    lvl_raw = lvl_x5[17:1];
    lvl_val = (lvl_raw > 17'(LEVEL_FULL)) ? LEVEL_OVER : lvl_raw[9:0];
  end

  // Control tick decision, evaluated from the current state.
  logic    t_usb, t_chg, t_done, t_upd, t_enable;
  logic [7:0] t_usb_cnt, t_low_cnt;
  status_e t_status;
  logic [9:0] t_level;

  always_comb begin
    t_usb     = usb_pres_q > thresh_q;
    t_chg     = chg_pres_q > thresh_q;
    t_done    = done_pres_q > thresh_q;
    t_upd     = 1'b0;
    t_enable  = enable_q;
    t_usb_cnt = usb_cnt_q;
    t_low_cnt = low_cnt_q;
    t_status  = status_q;
    t_level   = level_q;
    if (t_usb && (bat_mv_q < usb_limit_q)) begin
      if (usb_cnt_q >= usb_settle_q) begin
        t_enable = 1'b1;
        if (t_chg && !t_done) begin
          t_level   = lvl_val;
          t_status  = ST_CHARGING;
          t_low_cnt = 8'd0;
          t_upd     = 1'b1;
        end else if (t_done && !t_chg) begin
          t_level   = LEVEL_FULL;
          t_status  = ST_CHARGED;
          t_low_cnt = 8'd0;
          t_upd     = 1'b1;
        end
      end else if (usb_cnt_q != COUNT_MAX) begin
        t_usb_cnt = usb_cnt_q + 8'd1;
      end
    end else begin
      t_enable  = 1'b0;
      t_usb_cnt = 8'd0;
    end
    // Low-battery timer runs only when no new level was shown.
    if (!t_upd) begin
      if (bat_mv_q < low_mv_q) begin
        if (low_cnt_q > low_settle_q) begin
          t_status = ST_LOW;
        end
        if (low_cnt_q != COUNT_MAX) begin
          t_low_cnt = low_cnt_q + 8'd1;
        end
      end else if (status_q == ST_WORKING) begin
        t_low_cnt = 8'd0;
      end else if (status_q != ST_LOW) begin
        t_status = ST_WORKING;
      end
    end
  end

  assign direct_upd = (in_data_i.kind == KIND_TICK) && t_upd;

  // Operands of the current channel or pin.
  logic [SMOOTH_W-1:0] s_cur;
  logic [SUM_W-1:0]    sum_cur;
  logic [Q_W-1:0]      pres_cur;
  logic                pin_cur;

  always_comb begin
    s_cur   = (idx_q == CH_CHRG) ? chrg_s_q : vbat_s_q;
    sum_cur = (idx_q == CH_CHRG) ? chrg_sum_q : vbat_sum_q;
    unique case (idx_q)
      PIN_USB:  begin pres_cur = usb_pres_q;  pin_cur = pins_q[0]; end
      PIN_CHG:  begin pres_cur = chg_pres_q;  pin_cur = pins_q[1]; end
      PIN_DONE: begin pres_cur = done_pres_q; pin_cur = pins_q[2]; end
      default:  begin pres_cur = usb_pres_q;  pin_cur = pins_q[0]; end
    endcase
  end

  // Step decode: MAC beat and write-back strobes.
  mac_ctrl_t          mac_ctrl;
  logic [MAC_A_W-1:0] op_a;
  logic [MAC_B_W-1:0] op_b;
  logic [ACC_W-1:0]   acc;
  logic               wr_smooth, wr_mv, wr_pres;
  logic [MAC_B_W-1:0] inv_v_alpha, inv_p_alpha;

  assign inv_v_alpha = Q16_ONE - {1'b0, v_alpha_q};
  assign inv_p_alpha = Q16_ONE - {1'b0, p_alpha_q};

  always_comb begin
    mac_ctrl  = '{issue: 1'b0, clear: 1'b0, shift: SH_NONE};
    op_a      = MAC_A_W'(ROUND_Q16);
    op_b      = MAC_B_W'(1);
    wr_smooth = 1'b0;
    wr_mv     = 1'b0;
    wr_pres   = 1'b0;
    unique case (state_q)
      S_FILT: begin
        unique case (sub_q)
          F_ROUND: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b1, shift: SH_NONE};
          end
          F_MUL_LO: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b0, shift: SH_NONE};
            op_a     = MAC_A_W'(s_cur[SPLIT_W-1:0]);
            op_b     = inv_v_alpha;
          end
          F_MUL_HI: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b0, shift: SH_SPLIT};
            op_a     = MAC_A_W'(s_cur[SMOOTH_W-1:SPLIT_W]);
            op_b     = inv_v_alpha;
          end
          F_MUL_SUM: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b0, shift: SH_Q16};
            op_a     = sum_cur;
            op_b     = {1'b0, v_alpha_q};
          end
          F_WR_SMOOTH: begin
            wr_smooth = 1'b1;
            mac_ctrl  = '{issue: 1'b1, clear: 1'b1, shift: SH_SPLIT};
            op_a      = MAC_A_W'(HALF_DIV);
          end
          F_MV_LO: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b0, shift: SH_NONE};
            op_a     = MAC_A_W'(s_cur[SPLIT_W-1:0]);
            op_b     = {1'b0, full_scale_q};
          end
          F_MV_HI: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b0, shift: SH_SPLIT};
            op_a     = MAC_A_W'(s_cur[SMOOTH_W-1:SPLIT_W]);
            op_b     = {1'b0, full_scale_q};
          end
          F_WR_MV: wr_mv = 1'b1;
          default: ;
        endcase
      end
      S_PRES: begin
        unique case (sub_q)
          P_ROUND: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b1, shift: SH_NONE};
          end
          P_MUL: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b0, shift: SH_NONE};
            op_a     = MAC_A_W'(pres_cur);
            op_b     = inv_p_alpha;
          end
          P_PIN: begin
            mac_ctrl = '{issue: 1'b1, clear: 1'b0, shift: SH_Q16};
            op_a     = pin_cur ? MAC_A_W'(p_alpha_q) : '0;
          end
          P_WR:    wr_pres = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign seq_done = wr_pres && (idx_q == PIN_DONE);

  bcsm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  // Write-back values taken from the accumulator.
  logic [MV_W-1:0] mv_raw;
  logic [15:0]     mv_sat;

  assign mv_raw = acc[ACC_W-1:MV_SHIFT];
  assign mv_sat = (mv_raw > MV_W'(65535)) ? 16'hFFFF : mv_raw[15:0];

  // Next state of the monitor.
  always_comb begin
    vbat_sum_d  = vbat_sum_q;
    chrg_sum_d  = chrg_sum_q;
    vbat_s_d    = vbat_s_q;
    chrg_s_d    = chrg_s_q;
    bat_mv_d    = bat_mv_q;
    chg_mv_d    = chg_mv_q;
    usb_pres_d  = usb_pres_q;
    chg_pres_d  = chg_pres_q;
    done_pres_d = done_pres_q;
    usb_cnt_d   = usb_cnt_q;
    low_cnt_d   = low_cnt_q;
    status_d    = status_q;
    enable_d    = enable_q;
    level_d     = level_q;
    pins_d      = pins_q;
    if (accept) begin
      unique case (kind_e'(in_data_i.kind))
        KIND_SAMPLE: begin
          vbat_sum_d = vbat_sat;
          chrg_sum_d = chrg_sat;
          // Pins are held as asserted levels: present, charging, charged.
          if (in_data_i.block_end) begin
            pins_d = {!in_data_i.standby_pin, !in_data_i.charging_pin, in_data_i.usb_vbus_pin};
          end
        end
        KIND_TICK: begin
          usb_cnt_d = t_usb_cnt;
          low_cnt_d = t_low_cnt;
          status_d  = t_status;
          enable_d  = t_enable;
          level_d   = t_level;
        end
        KIND_VBUS_DROP: begin
          if (!in_data_i.usb_vbus_pin) begin
            enable_d    = 1'b0;
            usb_pres_d  = '0;
            chg_pres_d  = '0;
            done_pres_d = '0;
          end
        end
        KIND_NONE: ;
      endcase
    end
    if (wr_smooth) begin
      if (idx_q == CH_CHRG) chrg_s_d = acc[SMOOTH_W+15:16];
      else                  vbat_s_d = acc[SMOOTH_W+15:16];
    end
    if (wr_mv) begin
      if (idx_q == CH_CHRG) chg_mv_d = mv_sat;
      else                  bat_mv_d = mv_sat;
    end
    if (wr_pres) begin
      unique case (idx_q)
        PIN_USB:  usb_pres_d  = acc[Q_W+15:16];
        PIN_CHG:  chg_pres_d  = acc[Q_W+15:16];
        PIN_DONE: done_pres_d = acc[Q_W+15:16];
        default: ;
      endcase
    end
    if (seq_done) begin
      vbat_sum_d = '0;
      chrg_sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbat_sum_q  <= '0;
      chrg_sum_q  <= '0;
      vbat_s_q    <= '0;
      chrg_s_q    <= '0;
      bat_mv_q    <= '0;
      chg_mv_q    <= '0;
      usb_pres_q  <= '0;
      chg_pres_q  <= '0;
      done_pres_q <= '0;
      usb_cnt_q   <= '0;
      low_cnt_q   <= '0;
      status_q    <= ST_UNDEF;
      enable_q    <= 1'b0;
      level_q     <= '0;
      pins_q      <= '0;
    end else begin
      vbat_sum_q  <= vbat_sum_d;
      chrg_sum_q  <= chrg_sum_d;
      vbat_s_q    <= vbat_s_d;
      chrg_s_q    <= chrg_s_d;
      bat_mv_q    <= bat_mv_d;
      chg_mv_q    <= chg_mv_d;
      usb_pres_q  <= usb_pres_d;
      chg_pres_q  <= chg_pres_d;
      done_pres_q <= done_pres_d;
      usb_cnt_q   <= usb_cnt_d;
      low_cnt_q   <= low_cnt_d;
      status_q    <= status_d;
      enable_q    <= enable_d;
      level_q     <= level_d;
      pins_q      <= pins_d;
    end
  end

  // Sequencer, pending result and output register. A result that finds the output
  // register full waits as pending; its fields are the held state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sub_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_upd_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (slot_free) begin
        out_valid_q <= 1'b0;
      end
      if (pend_q && slot_free) begin
        out_valid_q <= 1'b1;
        out_q       <= '{status_code: status_q, charge_enable: enable_q,
                         charge_level_permille: level_q, level_updated: pend_upd_q,
                         battery_mv: bat_mv_q};
        pend_q      <= 1'b0;
      end else if (direct_done) begin
        if (slot_free) begin
          out_valid_q <= 1'b1;
          out_q       <= '{status_code: status_d, charge_enable: enable_d,
                           charge_level_permille: level_d, level_updated: direct_upd,
                           battery_mv: bat_mv_d};
        end else begin
          pend_q     <= 1'b1;
          pend_upd_q <= direct_upd;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && block_item) begin
            state_q <= S_FILT;
            sub_q   <= F_ROUND;
            idx_q   <= CH_VBAT;
          end
        end
        S_FILT: begin
          if (sub_q == F_WR_MV) begin
            sub_q <= '0;
            if (idx_q == CH_CHRG) begin
              state_q <= S_PRES;
              idx_q   <= PIN_USB;
            end else begin
              idx_q <= CH_CHRG;
            end
          end else begin
            sub_q <= sub_q + 4'd1;
          end
        end
        S_PRES: begin
          if (sub_q == P_WR) begin
            sub_q <= '0;
            if (idx_q == PIN_DONE) begin
              state_q    <= S_IDLE;
              pend_q     <= 1'b1;
              pend_upd_q <= 1'b0;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end else begin
            sub_q <= sub_q + 4'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
